FILE: rtl/sha512_pkg.sv
// sha512_pkg: shared constants, command codes and control structs for the sha-512 engine
// no dependencies
package sha512_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_DIGEST = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // schedule load source
    typedef enum logic [1:0] {
        SRC_BUF  = 2'd0,
        SRC_PAD1 = 2'd1,
        SRC_PAD2 = 2'd2
    } src_t;

    typedef struct packed {
        logic       init_hash;
        logic       buf_write;
        logic       load_word;
        logic [3:0] load_idx;
        src_t       load_src;
        logic       start_vars;
        logic       round_en;
        logic [6:0] round_idx;
        logic       fold;
        logic       fold_final;
        logic       snap_final;
        logic [2:0] out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic       wrap;
        logic       extra_block;
    } dp_stat_t;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        begin
            case (t)
                7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [63:0] init_h(input logic [2:0] i);
        logic [63:0] h;
        begin
            case (i)
                3'd0: h = 64'h6a09e667f3bcc908;
                3'd1: h = 64'hbb67ae8584caa73b;
                3'd2: h = 64'h3c6ef372fe94f82b;
                3'd3: h = 64'ha54ff53a5f1d36f1;
                3'd4: h = 64'h510e527fade682d1;
                3'd5: h = 64'h9b05688c2b3e6c1f;
                3'd6: h = 64'h1f83d9abfb41bd6b;
                default: h = 64'h5be0cd19137e2179;
            endcase
            return h;
        end
    endfunction

endpackage

FILE: rtl/sha512_datapath.sv
// sha512_datapath: block buffer, byte counters, schedule window, round unit and hash registers
// depends on sha512_pkg
module sha512_datapath
    import sha512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      ctl,
    input  logic [63:0]  data,
    input  logic [3:0]   byte_count,
    output dp_stat_t     stat,
    output logic [63:0]  digest_word
);

    // block buffer kept as sixteen big-endian words
    logic [63:0] buf_mem [0:15];
    logic [63:0] spill_reg;
    logic [6:0]  fill_reg;
    logic [63:0] total_reg;
    logic [63:0] hash_reg [0:7];
    logic [63:0] fin_reg  [0:7];
    logic [63:0] w_reg    [0:15];
    logic [63:0] v_reg    [0:7];

    logic [3:0]  cnt_sat;
    logic [7:0]  fill_sum;
    logic [3:0]  fit;
    logic [7:0]  wpos [0:7];
    logic [63:0] load_w;
    logic [63:0] w_cur;
    logic [63:0] s0, s1, t1, t2, e, a, w_new;

    assign cnt_sat  = (byte_count > 4'd8) ? 4'd8 : byte_count;
    assign fill_sum = {1'b0, fill_reg} + {4'd0, cnt_sat};
    // bytes left before the block end, only used when the item wraps
    assign fit      = 4'(8'd128 - {1'b0, fill_reg});
    assign stat.wrap        = fill_sum[7];
    assign stat.extra_block = (fill_reg >= 7'd112);

    always_comb
    begin
        for (int j = 0; j < 8; j++)
            wpos[j] = {1'b0, fill_reg} + 8'(j);
    end

    // word of the (possibly padded) block at load_idx
    always_comb
    begin
        logic [6:0] pos;
        load_w = '0;
        for (int j = 0; j < 8; j++)
        begin
            pos = {ctl.load_idx, 3'(j)};
            if (ctl.load_src == SRC_BUF || (ctl.load_src == SRC_PAD1 && pos < fill_reg))
                load_w[63-8*j -: 8] = buf_mem[ctl.load_idx][63-8*j -: 8];
            else if (ctl.load_src == SRC_PAD1 && pos == fill_reg)
                load_w[63-8*j -: 8] = 8'h80;
        end
        if (ctl.load_src != SRC_BUF && !(ctl.load_src == SRC_PAD1 && stat.extra_block))
        begin
            if (ctl.load_idx == 4'd14)
                load_w = {61'd0, total_reg[63:61]};
            else if (ctl.load_idx == 4'd15)
                load_w = {total_reg[60:0], 3'd0};
        end
        if (ctl.load_src == SRC_PAD2 && ctl.load_idx < 4'd14)
            load_w = '0;
    end

    always_comb
    begin
        s0 = {w_reg[1][0], w_reg[1][63:1]} ^ {w_reg[1][7:0], w_reg[1][63:8]}
           ^ (w_reg[1] >> 7);
        s1 = {w_reg[14][18:0], w_reg[14][63:19]} ^ {w_reg[14][60:0], w_reg[14][63:61]}
           ^ (w_reg[14] >> 6);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (ctl.round_idx < 7'd16) ? w_reg[0] : w_new;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(ctl.round_idx) + w_cur;
        t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.buf_write)
        begin
            for (int j = 0; j < 8; j++)
                if (4'(j) < cnt_sat && !wpos[j][7])
                    buf_mem[wpos[j][6:3]][63-8*wpos[j][2:0] -: 8] <= data[63-8*j -: 8];
            spill_reg <= data << {fit, 3'd0};
        end
        // bytes past the block end go to the front once word 0 has been loaded
        if (ctl.load_word && ctl.load_src == SRC_BUF && ctl.load_idx == 4'd0)
        begin
            for (int j = 0; j < 8; j++)
                if (7'(j) < fill_reg)
                    buf_mem[0][63-8*j -: 8] <= spill_reg[63-8*j -: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            total_reg    <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_h(3'(i));
        end
        else
        begin
            if (ctl.init_hash)
            begin
                fill_reg  <= '0;
                total_reg <= '0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= init_h(3'(i));
            end
            if (ctl.buf_write)
            begin
                fill_reg  <= fill_sum[6:0];
                total_reg <= total_reg + {60'd0, cnt_sat};
            end
            if (ctl.fold && !ctl.fold_final)
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.snap_final)
            for (int i = 0; i < 8; i++)
                fin_reg[i] <= hash_reg[i];
        if (ctl.fold && ctl.fold_final)
            for (int i = 0; i < 8; i++)
                fin_reg[i] <= fin_reg[i] + v_reg[i];
        if (ctl.load_word)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= load_w;
        end
        else if (ctl.round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_cur;
        end
        if (ctl.start_vars)
            for (int i = 0; i < 8; i++)
                v_reg[i] <= ctl.fold_final ? fin_reg[i] : hash_reg[i];
        else if (ctl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign digest_word = fin_reg[ctl.out_idx];

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load_word && ctl.round_en)) else $error("load and round together");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.buf_write && !ctl.init_hash |=> fill_reg == $past(fill_sum[6:0]))
        else $error("fill level step wrong");
    a_fold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fold |-> !ctl.round_en) else $error("fold during rounds");
`endif

endmodule

FILE: rtl/sha512_ctrl.sv
// sha512_ctrl: command sequencer for the sha-512 engine
// depends on sha512_pkg
module sha512_ctrl
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [1:0]  command,
    input  dp_stat_t    stat,
    output dp_cmd_t     ctl,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  word_index,
    output logic        last
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_VARS, ST_ROUND, ST_FOLD, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    src_t       src_reg, src_next;
    logic       dig_reg, dig_next;
    logic [2:0] oidx_reg, oidx_next;
    logic       acc;

    assign stall = (state_reg != ST_IDLE);
    assign acc   = valid && !stall;
    assign out_valid  = (state_reg == ST_EMIT);
    assign word_index = oidx_reg;
    assign last       = (oidx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        dig_next   = dig_reg;
        oidx_next  = oidx_reg;
        ctl = '0;
        ctl.load_src   = src_reg;
        ctl.load_idx   = cnt_reg[3:0];
        ctl.round_idx  = cnt_reg;
        ctl.fold_final = dig_reg;
        ctl.out_idx    = oidx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd_t'(command))
                        CMD_START: ctl.init_hash = 1'b1;
                        CMD_DATA:
                        begin
                            ctl.buf_write = 1'b1;
                            if (stat.wrap)
                            begin
                                state_next = ST_LOAD;
                                src_next   = SRC_BUF;
                                dig_next   = 1'b0;
                                cnt_next   = '0;
                            end
                        end
                        CMD_DIGEST:
                        begin
                            ctl.snap_final = 1'b1;
                            state_next = ST_LOAD;
                            src_next   = SRC_PAD1;
                            dig_next   = 1'b1;
                            cnt_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                ctl.load_word = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd15)
                    state_next = ST_VARS;
            end
            ST_VARS:
            begin
                ctl.start_vars = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctl.round_en = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd79)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctl.fold = 1'b1;
                cnt_next = '0;
                if (!dig_reg)
                    state_next = ST_IDLE;
                else if (src_reg == SRC_PAD1 && stat.extra_block)
                begin
                    src_next   = SRC_PAD2;
                    state_next = ST_LOAD;
                end
                else
                begin
                    oidx_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            src_reg   <= SRC_BUF;
            dig_reg   <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            src_reg   <= src_next;
            dig_reg   <= dig_next;
            oidx_reg  <= oidx_next;
        end
    end

`ifndef SYNTHESIS
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> cnt_reg < 7'd80) else $error("round count overrun");
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> state_reg == ST_IDLE)
        else $error("emit did not finish");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> stall) else $error("accepting while busy");
`endif

endmodule

FILE: rtl/sha512_hash_engine.sv
// sha512_hash_engine: top level of the sha-512 engine
// depends on sha512_pkg, sha512_ctrl, sha512_datapath
//
//  channel  | handshake            | fields
//  input    | in_valid / in_stall  | command, data, byte_count
//  output   | out_valid / out_stall| digest_word, word_index, last
//
// a start or data item that fills no block leaves the engine idle
// an item that completes a block is followed by 16 word loads, a variable setup, 80 rounds and a fold
// a digest runs one padded block, or two (extra block at fill 112+), then eight output items
// rst_n is asynchronous; the running hash resets to the initial values
// out_stall holds the current word; in_stall is high while a block or digest is in work
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [63:0] data,
    input  logic [3:0]  byte_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    sha512_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid),
        .stall      (in_stall),
        .command    (command),
        .stat       (stat),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (word_index),
        .last       (last)
    );

    sha512_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .data        (data),
        .byte_count  (byte_count),
        .stat        (stat),
        .digest_word (digest_word)
    );

endmodule
